[hdl/gpioirq_pkg.sv]
package gpioirq_pkg;

   localparam int BANK_WIDTH = 32;
   localparam int FSEL_WORDS = 6;
   localparam int PINS_PER_SEL = 10;
   localparam int FUNC_WIDTH = 3;
   localparam int HIGH_LEVELS_WIDTH = 22;
   localparam int WORD_IDX_WIDTH = 6;
   localparam int PIN_IDX_WIDTH = 6;
   localparam int ENABLE_KINDS = 4;

   typedef logic [WORD_IDX_WIDTH-1:0] word_idx_type;

   localparam word_idx_type W_FSEL_LAST = 6'd5;
   localparam word_idx_type W_SET0 = 6'd7;
   localparam word_idx_type W_SET1 = 6'd8;
   localparam word_idx_type W_CLR0 = 6'd10;
   localparam word_idx_type W_CLR1 = 6'd11;
   localparam word_idx_type W_LEV0 = 6'd13;
   localparam word_idx_type W_LEV1 = 6'd14;
   localparam word_idx_type W_EDS0 = 6'd16;
   localparam word_idx_type W_EDS1 = 6'd17;
   localparam word_idx_type W_REN0 = 6'd19;
   localparam word_idx_type W_REN1 = 6'd20;
   localparam word_idx_type W_FEN0 = 6'd22;
   localparam word_idx_type W_FEN1 = 6'd23;
   localparam word_idx_type W_HEN0 = 6'd25;
   localparam word_idx_type W_HEN1 = 6'd26;
   localparam word_idx_type W_LEN0 = 6'd28;
   localparam word_idx_type W_LEN1 = 6'd29;

   localparam logic [FUNC_WIDTH-1:0] FUNC_INPUT = 3'd0;
   localparam logic [FUNC_WIDTH-1:0] FUNC_OUTPUT = 3'd1;

   localparam logic [1:0] EN_RISE = 2'd0;
   localparam logic [1:0] EN_FALL = 2'd1;
   localparam logic [1:0] EN_HIGH = 2'd2;
   localparam logic [1:0] EN_LOW = 2'd3;

   typedef enum logic [1:0] {
      REQ_READ = 2'd0,
      REQ_WRITE = 2'd1,
      REQ_DRIVE = 2'd2
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_OK = 3'd0,
      ST_REJECTED = 3'd1,
      ST_BAD_PIN = 3'd2,
      ST_NOT_INPUT = 3'd3,
      ST_ALREADY_SET = 3'd4
   } status_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] byte_addr;
      logic [2:0] access_size;
      logic [31:0] write_data;
      logic [5:0] drive_pin;
      logic drive_level;
   } req_word_type;

   typedef struct packed {
      logic [31:0] read_data;
      status_type status;
      logic irq_raise;
      logic [5:0] irq_raise_pin;
      logic [31:0] irq_clear_mask;
      logic irq_clear_upper;
      logic [31:0] levels_low_bank;
      logic [HIGH_LEVELS_WIDTH-1:0] levels_high_bank;
   } rsp_word_type;

   typedef struct packed {
      logic rd_en;
      word_idx_type rd_word;
      logic wr_en;
      word_idx_type wr_word;
      logic [31:0] wr_data;
   } store_ctl_type;

endpackage

[hdl/gpioirq_store.sv]
module gpioirq_store #(
   parameter int DEPTH = 41
) (
   input logic clock,
   input logic reset,
   input gpioirq_pkg::store_ctl_type ctl,
   output logic [31:0] rd_data
);

   localparam int AW = $clog2(DEPTH);

   logic [31:0] mem_ff [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [DEPTH-1:0] valid_in;
   logic [31:0] data_ff;
   logic [AW-1:0] rd_idx;
   logic [AW-1:0] wr_idx;
   logic rd_in_range;

   assign rd_idx = ctl.rd_word[AW-1:0];
   assign wr_idx = ctl.wr_word[AW-1:0];
   assign rd_in_range = {1'b0, ctl.rd_word} < 7'(DEPTH);

   always_comb begin
      valid_in = valid_ff;
      if (ctl.wr_en) begin
         valid_in[wr_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_ff[wr_idx] <= ctl.wr_data;
      end
      if (ctl.rd_en) begin
         if (ctl.wr_en && ctl.wr_word == ctl.rd_word) begin
            data_ff <= ctl.wr_data;
         end else if (rd_in_range && valid_ff[rd_idx]) begin
            data_ff <= mem_ff[rd_idx];
         end else begin
            data_ff <= '0;
         end
      end
   end

   assign rd_data = data_ff;

endmodule

[hdl/gpio_controller_with_edge_level_irq_unit.sv]
// GPIO controller with a 32-bit register map and per-pin rising, falling, high and low
// interrupt detection. Each request word is a bus read, a bus write or an external drive
// of one pin, and each produces exactly one response word. One request word is accepted
// every cycle unless the response side stalls; its response word passes through the input
// register, where the storage word is read, and then the response register, where it is
// held for as long as the response side stalls.
// Storage words come up as zero after reset through per-word valid bits, so no clearing
// pass is needed and requests are taken at once.
module gpio_controller_with_edge_level_irq_unit #(
   parameter int PIN_COUNT = 54,
   parameter int REG_WORD_COUNT = 41
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input gpioirq_pkg::req_word_type req_word,
   output logic rsp_valid,
   input logic rsp_stall,
   output gpioirq_pkg::rsp_word_type rsp_word
);

   localparam int PW = $clog2(PIN_COUNT);
   localparam int BW = gpioirq_pkg::BANK_WIDTH;

   gpioirq_pkg::req_word_type req_ff;
   logic s1_valid_ff;
   logic s1_valid_in;
   gpioirq_pkg::rsp_word_type rsp_ff;
   gpioirq_pkg::rsp_word_type rsp_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic advance;
   logic accept;

   logic [31:0] fsel_ff [gpioirq_pkg::FSEL_WORDS];
   logic [31:0] fsel_in [gpioirq_pkg::FSEL_WORDS];
   logic [31:0] en_ff [gpioirq_pkg::ENABLE_KINDS][2];
   logic [31:0] en_in [gpioirq_pkg::ENABLE_KINDS][2];
   logic [PIN_COUNT-1:0] level_ff;
   logic [PIN_COUNT-1:0] level_in;
   logic [PIN_COUNT-1:0] pend_ff;
   logic [PIN_COUNT-1:0] pend_in;

   logic [PIN_COUNT-1:0] is_input;
   logic [PIN_COUNT-1:0] is_output;

   gpioirq_pkg::store_ctl_type store_ctl;
   logic [31:0] store_data;

   gpioirq_pkg::word_idx_type word;
   logic [1:0] off;
   logic [4:0] lane;
   logic [3:0] size_bytes;
   logic [3:0] byte_mask;
   logic [31:0] bit_mask;
   logic [31:0] shifted;
   logic [31:0] old_word;
   logic [31:0] merged;
   logic [31:0] read_val;
   logic bad_access;
   logic bank;
   logic en_hit;
   logic [1:0] en_kind;
   logic [63:0] lev64;
   logic [63:0] pend64;
   logic [63:0] bank_bits64;
   logic [63:0] lev_next64;
   logic [31:0] clear_bits;
   logic [63:0] clear64;
   logic [PW-1:0] pidx;
   logic pin_bad;
   logic fire;
   logic nv;
   logic plain_write;

   for (genvar p = 0; p < PIN_COUNT; p++) begin : g_pin
      if (p < gpioirq_pkg::FSEL_WORDS * gpioirq_pkg::PINS_PER_SEL) begin : g_sel
         assign is_input[p] = fsel_ff[p / gpioirq_pkg::PINS_PER_SEL]
            [gpioirq_pkg::FUNC_WIDTH * (p % gpioirq_pkg::PINS_PER_SEL) +: gpioirq_pkg::FUNC_WIDTH]
            == gpioirq_pkg::FUNC_INPUT;
         assign is_output[p] = fsel_ff[p / gpioirq_pkg::PINS_PER_SEL]
            [gpioirq_pkg::FUNC_WIDTH * (p % gpioirq_pkg::PINS_PER_SEL) +: gpioirq_pkg::FUNC_WIDTH]
            == gpioirq_pkg::FUNC_OUTPUT;
      end else begin : g_fixed
         // Pins past the last function-select word stay inputs.
         assign is_input[p] = 1'b1;
         assign is_output[p] = 1'b0;
      end
   end

   assign advance = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign accept = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Address decode, byte lanes, the current value of the addressed word and the drive pin check.
   always_comb begin
      word = req_ff.byte_addr[7:2];
      off = req_ff.byte_addr[1:0];
      lane = {off, 3'b000};
      case (req_ff.access_size)
         3'd1: size_bytes = 4'b0001;
         3'd2: size_bytes = 4'b0011;
         3'd3: size_bytes = 4'b0111;
         3'd4: size_bytes = 4'b1111;
         default: size_bytes = 4'b0000;
      endcase
      byte_mask = size_bytes << off;
      bad_access = (size_bytes == 4'b0000)
         || (({2'b00, off} + {1'b0, req_ff.access_size}) > 4'd4)
         || ({1'b0, word} >= 7'(REG_WORD_COUNT));
      for (int i = 0; i < 4; i++) begin
         bit_mask[8 * i +: 8] = {8{byte_mask[i]}};
      end
      shifted = req_ff.write_data << lane;

      bank = (word == gpioirq_pkg::W_SET1) || (word == gpioirq_pkg::W_CLR1)
         || (word == gpioirq_pkg::W_EDS1);
      en_hit = 1'b1;
      en_kind = gpioirq_pkg::EN_RISE;
      case (word)
         gpioirq_pkg::W_REN0, gpioirq_pkg::W_REN1: en_kind = gpioirq_pkg::EN_RISE;
         gpioirq_pkg::W_FEN0, gpioirq_pkg::W_FEN1: en_kind = gpioirq_pkg::EN_FALL;
         gpioirq_pkg::W_HEN0, gpioirq_pkg::W_HEN1: en_kind = gpioirq_pkg::EN_HIGH;
         gpioirq_pkg::W_LEN0, gpioirq_pkg::W_LEN1: en_kind = gpioirq_pkg::EN_LOW;
         default: en_hit = 1'b0;
      endcase
      if (en_hit) begin
         bank = (word == gpioirq_pkg::W_REN1) || (word == gpioirq_pkg::W_FEN1)
            || (word == gpioirq_pkg::W_HEN1) || (word == gpioirq_pkg::W_LEN1);
      end

      lev64 = 64'(level_ff);
      pend64 = 64'(pend_ff);
      plain_write = 1'b0;
      case (word) inside
         [6'd0:gpioirq_pkg::W_FSEL_LAST]: old_word = fsel_ff[word[2:0]];
         gpioirq_pkg::W_LEV0: old_word = lev64[BW-1:0];
         gpioirq_pkg::W_LEV1: old_word = lev64[2*BW-1:BW];
         gpioirq_pkg::W_SET0, gpioirq_pkg::W_SET1, gpioirq_pkg::W_CLR0, gpioirq_pkg::W_CLR1,
         gpioirq_pkg::W_EDS0, gpioirq_pkg::W_EDS1: old_word = '0;
         gpioirq_pkg::W_REN0, gpioirq_pkg::W_REN1, gpioirq_pkg::W_FEN0, gpioirq_pkg::W_FEN1,
         gpioirq_pkg::W_HEN0, gpioirq_pkg::W_HEN1, gpioirq_pkg::W_LEN0,
         gpioirq_pkg::W_LEN1: old_word = en_ff[en_kind][bank];
         default: begin
            old_word = store_data;
            plain_write = 1'b1;
         end
      endcase
      merged = (old_word & ~bit_mask) | (shifted & bit_mask);
      read_val = (old_word & bit_mask) >> lane;
      bank_bits64 = bank ? {merged, 32'h0} : {32'h0, merged};
      clear_bits = merged & (bank ? pend64[2*BW-1:BW] : pend64[BW-1:0]);
      clear64 = bank ? {clear_bits, 32'h0} : {32'h0, clear_bits};

      pidx = req_ff.drive_pin[PW-1:0];
      pin_bad = {1'b0, req_ff.drive_pin} >= 7'(PIN_COUNT);
      nv = req_ff.drive_level;
      fire = (en_ff[gpioirq_pkg::EN_RISE][req_ff.drive_pin[5]][req_ff.drive_pin[4:0]] && nv)
         || (en_ff[gpioirq_pkg::EN_FALL][req_ff.drive_pin[5]][req_ff.drive_pin[4:0]] && !nv)
         || (en_ff[gpioirq_pkg::EN_LOW][req_ff.drive_pin[5]][req_ff.drive_pin[4:0]] && !nv)
         || (en_ff[gpioirq_pkg::EN_HIGH][req_ff.drive_pin[5]][req_ff.drive_pin[4:0]] && nv);
   end

   // Effect of the request on the pin state and the response word.
   always_comb begin
      fsel_in = fsel_ff;
      en_in = en_ff;
      level_in = level_ff;
      pend_in = pend_ff;
      rsp_in = '0;
      rsp_in.status = gpioirq_pkg::ST_OK;
      store_ctl.rd_en = accept;
      store_ctl.rd_word = req_word.byte_addr[7:2];
      store_ctl.wr_en = 1'b0;
      store_ctl.wr_word = word;
      store_ctl.wr_data = merged;
      case (req_ff.req_type)
         gpioirq_pkg::REQ_DRIVE: begin
            if (pin_bad) begin
               rsp_in.status = gpioirq_pkg::ST_BAD_PIN;
            end else if (!is_input[pidx]) begin
               rsp_in.status = gpioirq_pkg::ST_NOT_INPUT;
            end else if (level_ff[pidx] == nv) begin
               rsp_in.status = gpioirq_pkg::ST_ALREADY_SET;
            end else begin
               level_in[pidx] = nv;
               if (fire) begin
                  pend_in[pidx] = 1'b1;
                  rsp_in.irq_raise = 1'b1;
                  rsp_in.irq_raise_pin = req_ff.drive_pin;
               end
            end
         end
         gpioirq_pkg::REQ_READ: begin
            if (bad_access || word == gpioirq_pkg::W_SET0 || word == gpioirq_pkg::W_SET1
                  || word == gpioirq_pkg::W_CLR0 || word == gpioirq_pkg::W_CLR1) begin
               rsp_in.status = gpioirq_pkg::ST_REJECTED;
            end else begin
               rsp_in.read_data = read_val;
            end
         end
         gpioirq_pkg::REQ_WRITE: begin
            if (bad_access || word == gpioirq_pkg::W_LEV0 || word == gpioirq_pkg::W_LEV1) begin
               rsp_in.status = gpioirq_pkg::ST_REJECTED;
            end else begin
               case (word) inside
                  [6'd0:gpioirq_pkg::W_FSEL_LAST]: fsel_in[word[2:0]] = merged;
                  gpioirq_pkg::W_SET0, gpioirq_pkg::W_SET1: begin
                     level_in = level_ff | (bank_bits64[PIN_COUNT-1:0] & is_output);
                  end
                  gpioirq_pkg::W_CLR0, gpioirq_pkg::W_CLR1: begin
                     level_in = level_ff & ~(bank_bits64[PIN_COUNT-1:0] & is_output);
                  end
                  gpioirq_pkg::W_EDS0, gpioirq_pkg::W_EDS1: begin
                     rsp_in.irq_clear_upper = bank;
                     rsp_in.irq_clear_mask = clear_bits;
                     pend_in = pend_ff & ~clear64[PIN_COUNT-1:0];
                  end
                  default: begin
                     if (en_hit) begin
                        en_in[en_kind][bank] = merged;
                     end
                     store_ctl.wr_en = plain_write && advance;
                  end
               endcase
            end
         end
         default: rsp_in.status = gpioirq_pkg::ST_REJECTED;
      endcase
      lev_next64 = 64'(level_in);
      rsp_in.levels_low_bank = lev_next64[BW-1:0];
      rsp_in.levels_high_bank = lev_next64[BW +: gpioirq_pkg::HIGH_LEVELS_WIDTH];
   end

   gpioirq_store #(
      .DEPTH(REG_WORD_COUNT)
   ) u_store (
      .clock(clock),
      .reset(reset),
      .ctl(store_ctl),
      .rd_data(store_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         level_ff <= '0;
         pend_ff <= '0;
         for (int i = 0; i < gpioirq_pkg::FSEL_WORDS; i++) begin
            fsel_ff[i] <= '0;
         end
         for (int k = 0; k < gpioirq_pkg::ENABLE_KINDS; k++) begin
            en_ff[k][0] <= '0;
            en_ff[k][1] <= '0;
         end
      end else begin
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            level_ff <= level_in;
            pend_ff <= pend_in;
            fsel_ff <= fsel_in;
            en_ff <= en_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_word;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word = rsp_ff;

   a_irq_only_when_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.irq_raise |->
         rsp_ff.status == gpioirq_pkg::ST_OK && rsp_ff.irq_clear_mask == '0)
      else $error("Interrupt raised on a response word that is not ok.");

   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status != gpioirq_pkg::ST_OK |->
         rsp_ff.read_data == '0 && !rsp_ff.irq_raise && rsp_ff.irq_clear_mask == '0)
      else $error("A failed request returned data or interrupt effects.");

   a_levels_hold: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$past(advance) |-> $stable(level_ff) && $stable(pend_ff))
      else $error("Pin state changed without a request word completing.");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && rsp_valid_ff && rsp_stall)
      else $error("Request side stalled without a blocked response word.");

endmodule
